// ----- rtl/p1305_pkg.sv -----
package p1305_pkg;

    localparam int unsigned LIMB_W = 26;
    localparam int unsigned NLIMB = 5;
    localparam int unsigned ACC_W = 64;

    localparam logic [63:0] CLAMP_LOW = 64'h0ffffffc0fffffff;
    localparam logic [63:0] CLAMP_HIGH = 64'h0ffffffc0ffffffc;

    localparam logic [1:0] REG_R_LOW = 2'd0;
    localparam logic [1:0] REG_R_HIGH = 2'd1;
    localparam logic [1:0] REG_S_LOW = 2'd2;
    localparam logic [1:0] REG_S_HIGH = 2'd3;

    typedef logic [LIMB_W-1:0] t_limb;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the padded block into h + block
        logic skip;      // zero-byte last item: keep h as it is
        logic mul_row;   // accumulate one product row
        logic settle;    // one carry pass over the product columns
        logic finish;    // full reduction, add s, register the tag
        logic clear;     // clear the accumulator
    } t_cmd;

    // Status from the datapath.
    typedef struct packed {
        logic row_last;  // the current row is the fifth one
        logic pass_last; // the current carry pass is the third one
    } t_stat;

endpackage

// ----- rtl/p1305_ctrl.sv -----
module p1305_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic             i_last,
    input  logic [4:0]       i_byte_count,
    output logic             o_valid,
    input  logic             i_stall,
    input  p1305_pkg::t_stat i_stat,
    output p1305_pkg::t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SETTLE,
        S_FINISH,
        S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_last, n_last;
    logic   r_valid, n_valid;
    logic   w_acc;

    assign w_acc = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_valid;

    // Command decode from the state and the input handshake.
    always_comb begin
        o_cmd = '0;
        o_cmd.load = w_acc;
        o_cmd.skip = w_acc && i_last && (i_byte_count == 5'd0);
        o_cmd.mul_row = (r_state == S_MUL);
        o_cmd.settle = (r_state == S_SETTLE);
        o_cmd.finish = (r_state == S_FINISH);
        o_cmd.clear = (r_state == S_FINISH);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        n_last = r_last;
        n_valid = r_valid;
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    n_last = i_last;
                    if (i_last && i_byte_count == 5'd0) begin
                        n_state = S_FINISH;
                    end else begin
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                if (i_stat.row_last) begin
                    n_state = S_SETTLE;
                end
            end
            S_SETTLE: begin
                if (i_stat.pass_last) begin
                    n_state = r_last ? S_FINISH : S_IDLE;
                end
            end
            S_FINISH: begin
                n_valid = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_stall) begin
                    n_valid = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_last <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_last <= n_last;
            r_valid <= n_valid;
        end
    end

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && i_stall |=> r_valid)
        else $error("result dropped while stalled");
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> o_stall)
        else $error("input taken while a result waits");
    a_finish_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> r_valid)
        else $error("finish did not raise the result");
`endif

endmodule

// ----- rtl/p1305_dp.sv -----
module p1305_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  p1305_pkg::t_cmd  i_cmd,
    output p1305_pkg::t_stat o_stat,
    input  logic [63:0]      i_block_low,
    input  logic [63:0]      i_block_high,
    input  logic [4:0]       i_byte_count,
    input  logic             i_last,
    input  logic [63:0]      i_r_low,
    input  logic [63:0]      i_r_high,
    input  logic [63:0]      i_s_low,
    input  logic [63:0]      i_s_high,
    output logic [63:0]      o_tag_low,
    output logic [63:0]      o_tag_high
);

    localparam int unsigned LW = p1305_pkg::LIMB_W;
    localparam int unsigned AW = p1305_pkg::ACC_W;

    p1305_pkg::t_limb r_acc [5];
    logic [LW:0]      r_h [5];     // h + block, up to 27 bits
    logic [AW-1:0]    r_d [5];     // product columns
    logic [2:0]       r_row;
    logic [1:0]       r_pass;
    logic [63:0]      r_tag_low, r_tag_high;

    logic [63:0]  w_lo, w_hi;
    logic         w_top;
    logic [127:0] w_blk, w_rc;
    logic [4:0]   w_n;
    logic [LW-1:0] w_r [5];
    logic [AW-1:0] w_prod [5];
    logic [LW:0]   w_hrow;
    logic [2:0]    w_k;

    // Pad the block according to the byte count.
    always_comb begin
        w_n = (i_byte_count > 5'd16) ? 5'd16 : i_byte_count;
        w_lo = i_block_low;
        w_hi = i_block_high;
        w_top = 1'b1;
        if (i_last && w_n != 5'd16) begin
            w_top = 1'b0;
            if (w_n < 5'd8) begin
                w_lo = (i_block_low & ((64'd1 << {w_n[2:0], 3'b000}) - 64'd1))
                       | (64'd1 << {w_n[2:0], 3'b000});
                w_hi = '0;
            end else begin
                w_hi = (i_block_high & ((64'd1 << {w_n[2:0], 3'b000}) - 64'd1))
                       | (64'd1 << {w_n[2:0], 3'b000});
            end
        end
        w_blk = {w_hi, w_lo};
        w_rc = {i_r_high & p1305_pkg::CLAMP_HIGH, i_r_low & p1305_pkg::CLAMP_LOW};
    end

    // Clamped r limbs.
    always_comb begin
        for (int i = 0; i < 5; i++) begin
            w_r[i] = LW'(w_rc >> (LW * i));
        end
    end

    // One row: h[row] times r rotated, with the wrapped terms times five.
    assign w_hrow = r_h[r_row];
    always_comb begin
        for (int i = 0; i < 5; i++) begin
            if (int'(r_row) <= i) begin
                w_k = 3'(i - int'(r_row));
                w_prod[i] = AW'(w_hrow) * AW'(w_r[w_k]);
            end else begin
                w_k = 3'(i + 5 - int'(r_row));
                w_prod[i] = AW'(w_hrow) * (AW'(w_r[w_k]) * AW'(5));
            end
        end
    end

    assign o_stat.row_last = (r_row == 3'd4);
    assign o_stat.pass_last = (r_pass == 2'd2);

    // Accumulator, product rows and tag.
    always_ff @(posedge i_clk) begin
        logic [AW-1:0] t [5];
        logic [AW-1:0] c;
        logic [LW:0] g [5];
        logic [LW:0] gc;
        logic [LW-1:0] f [5];
        logic [127:0] hv;
        logic [64:0] sl;
        if (!i_rst_n) begin
            for (int i = 0; i < 5; i++) begin
                r_acc[i] <= '0;
            end
            r_row <= '0;
            r_pass <= '0;
        end else begin
            if (i_cmd.load && !i_cmd.skip) begin
                for (int i = 0; i < 4; i++) begin
                    r_h[i] <= (LW + 1)'(r_acc[i]) + (LW + 1)'(LW'(w_blk >> (LW * i)));
                end
                r_h[4] <= (LW + 1)'(r_acc[4]) + (LW + 1)'(LW'(w_blk >> (LW * 4)))
                          + (w_top ? (LW + 1)'(1 << 24) : (LW + 1)'(0));
                for (int i = 0; i < 5; i++) begin
                    r_d[i] <= '0;
                end
                r_row <= '0;
                r_pass <= '0;
            end
            if (i_cmd.mul_row) begin
                for (int i = 0; i < 5; i++) begin
                    r_d[i] <= r_d[i] + w_prod[i];
                end
                r_row <= (r_row == 3'd4) ? 3'd0 : r_row + 3'd1;
            end
            // One carry pass per cycle; the third pass lands in the accumulator.
            if (i_cmd.settle) begin
                c = '0;
                for (int i = 0; i < 5; i++) begin
                    t[i] = r_d[i] + c;
                    c = t[i] >> LW;
                    t[i] = t[i] & AW'(26'h3ffffff);
                end
                t[0] = t[0] + c * AW'(5);
                for (int i = 0; i < 5; i++) begin
                    r_d[i] <= t[i];
                end
                if (r_pass == 2'd2) begin
                    for (int i = 0; i < 5; i++) begin
                        r_acc[i] <= LW'(t[i]);
                    end
                end
                r_pass <= (r_pass == 2'd2) ? 2'd0 : r_pass + 2'd1;
            end
            if (i_cmd.finish) begin
                gc = (LW + 1)'(5);
                for (int i = 0; i < 5; i++) begin
                    g[i] = (LW + 1)'(r_acc[i]) + gc;
                    gc = (LW + 1)'(g[i][LW]);
                end
                for (int i = 0; i < 5; i++) begin
                    f[i] = (gc != '0) ? g[i][LW-1:0] : r_acc[i];
                end
                hv = 128'({f[4], f[3], f[2], f[1], f[0]});
                sl = {1'b0, hv[63:0]} + {1'b0, i_s_low};
                r_tag_low <= sl[63:0];
                r_tag_high <= hv[127:64] + i_s_high + 64'(sl[64]);
            end
            if (i_cmd.clear) begin
                for (int i = 0; i < 5; i++) begin
                    r_acc[i] <= '0;
                end
            end
        end
    end

    assign o_tag_low = r_tag_low;
    assign o_tag_high = r_tag_high;

endmodule

// ----- rtl/poly1305_mac_core.sv -----
// Channel  | Direction | Handshake          | Payload
// input    | in        | i_valid / o_stall  | i_block_low, i_block_high, i_byte_count, i_last
// result   | out       | o_valid / i_stall  | o_tag_low, o_tag_high
// config   | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// A block takes a load, five product rows and three carry passes.
// A last item adds a finish step before the tag is shown.
// A last item with no bytes goes from the load cycle straight to finish.
// Reset is synchronous, active low, and clears the accumulator and control.
// While a tag waits under stall, no new item is taken.
module poly1305_mac_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_block_low,
    input  logic [63:0] i_block_high,
    input  logic [4:0]  i_byte_count,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_tag_low,
    output logic [63:0] o_tag_high,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    p1305_pkg::t_cmd  w_cmd;
    p1305_pkg::t_stat w_stat;
    logic [63:0] r_r_low, r_r_high, r_s_low, r_s_high;

    assign o_cfg_ready = 1'b1;

    // Key registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_low <= '0;
            r_r_high <= '0;
            r_s_low <= '0;
            r_s_high <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                p1305_pkg::REG_R_LOW: r_r_low <= i_cfg_data;
                p1305_pkg::REG_R_HIGH: r_r_high <= i_cfg_data;
                p1305_pkg::REG_S_LOW: r_s_low <= i_cfg_data;
                p1305_pkg::REG_S_HIGH: r_s_high <= i_cfg_data;
                default: r_r_low <= r_r_low;
            endcase
        end
    end

    p1305_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_last(i_last), .i_byte_count(i_byte_count),
        .o_valid(o_valid), .i_stall(i_stall),
        .i_stat(w_stat), .o_cmd(w_cmd)
    );

    p1305_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(w_cmd), .o_stat(w_stat),
        .i_block_low(i_block_low), .i_block_high(i_block_high),
        .i_byte_count(i_byte_count), .i_last(i_last),
        .i_r_low(r_r_low), .i_r_high(r_r_high),
        .i_s_low(r_s_low), .i_s_high(r_s_high),
        .o_tag_low(o_tag_low), .o_tag_high(o_tag_high)
    );

endmodule

// ----- verif/tb_poly1305_mac_core.sv -----
`timescale 1ns / 100ps

module tb_poly1305_mac_core;

    // One message block as offered on the input channel.
    typedef struct {
        logic [63:0] blk_lo;
        logic [63:0] blk_hi;
        logic [4:0]  nbytes;
        logic        is_last;
    } t_block_item;

    typedef struct {
        logic [63:0] lo;
        logic [63:0] hi;
    } t_tag;

    localparam logic [129:0] PRIME = (130'd1 << 130) - 130'd5;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [63:0] i_block_low;
    logic [63:0] i_block_high;
    logic [4:0]  i_byte_count;
    logic        i_last;
    logic        o_valid;
    logic        i_stall;
    logic [63:0] o_tag_low;
    logic [63:0] o_tag_high;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [63:0] i_cfg_data;

    poly1305_mac_core dut (.*);

    t_block_item pending_blocks[$];
    t_tag        expected_tags[$];
    logic [63:0] key_r_lo, key_r_hi, key_s_lo, key_s_hi;
    logic [129:0] acc_h;
    int          err_count;
    bit          hold_req;
    bit          hold_on;
    bit          send_gaps;

    // Clock generator.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Report one mismatch and count it.
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        err_count++;
    endtask

    // Absorb one padded block: h = (h + blk) * r mod p.
    function automatic void absorb_block(input logic [128:0] blk);
        logic [129:0] r_val;
        logic [259:0] prod;
        r_val = {2'b0, key_r_hi & p1305_pkg::CLAMP_HIGH, key_r_lo & p1305_pkg::CLAMP_LOW};
        prod = (260'(acc_h) + 260'(blk)) * 260'(r_val);
        acc_h = 130'(prod % 260'(PRIME));
    endfunction

    // Work out the tag, if any, that an accepted block brings.
    function automatic void predict_block(input t_block_item it);
        logic [127:0] msg, mask;
        logic [128:0] tag_sum;
        int unsigned n;
        msg = {it.blk_hi, it.blk_lo};
        if (!it.is_last) begin
            absorb_block({1'b1, msg});
            return;
        end
        n = (it.nbytes > 16) ? 16 : it.nbytes;
        if (n == 16) begin
            absorb_block({1'b1, msg});
        end else if (n > 0) begin
            mask = (128'd1 << (8 * n)) - 128'd1;
            absorb_block({1'b0, (msg & mask) | (128'd1 << (8 * n))});
        end
        tag_sum = 129'(acc_h % PRIME) + 129'({key_s_hi, key_s_lo});
        expected_tags.push_back('{tag_sum[63:0], tag_sum[127:64]});
        acc_h = '0;
    endfunction

    function automatic t_block_item random_block(input bit want_last);
        t_block_item it;
        it.blk_lo = {$urandom, $urandom};
        it.blk_hi = {$urandom, $urandom};
        it.is_last = want_last;
        it.nbytes = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(17, 31))
                                                : 5'($urandom_range(0, 16));
        if ($urandom_range(0, 7) == 0) begin
            it.blk_lo = $urandom_range(0, 1) ? '1 : '0;
            it.blk_hi = $urandom_range(0, 1) ? '1 : '0;
        end
        return it;
    endfunction

    function automatic int gap_len();
        return ($urandom_range(0, 19) == 0) ? $urandom_range(8, 30)
                                            : $urandom_range(0, 2);
    endfunction

    // Driver: offers queued items, with random gaps when send_gaps is set.
    int send_wait;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_block_low <= '0;
            i_block_high <= '0;
            i_byte_count <= '0;
            i_last <= 1'b0;
            send_wait <= 0;
        end else begin
            if (i_valid && !o_stall) begin
                predict_block('{i_block_low, i_block_high, i_byte_count, i_last});
            end
            if (!i_valid || !o_stall) begin
                if (send_wait > 0) begin
                    i_valid <= 1'b0;
                    send_wait <= send_wait - 1;
                end else if (pending_blocks.size() > 0) begin
                    t_block_item it;
                    it = pending_blocks.pop_front();
                    i_valid <= 1'b1;
                    i_block_low <= it.blk_lo;
                    i_block_high <= it.blk_hi;
                    i_byte_count <= it.nbytes;
                    i_last <= it.is_last;
                    send_wait <= send_gaps ? gap_len() : 0;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Long hold on the result side, counted in cycles once requested.
    initial begin
        hold_on = 1'b0;
        wait (hold_req);
        @(posedge i_clk);
        hold_on <= 1'b1;
        repeat (400) @(posedge i_clk);
        hold_on <= 1'b0;
    end

    // Monitor: random stall, an optional long hold, and tag checking.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_tags.size() == 0) begin
                    report_mismatch("unexpected tag", o_tag_low, '0);
                end else begin
                    t_tag want;
                    want = expected_tags.pop_front();
                    if (o_tag_low !== want.lo) report_mismatch("tag_low", o_tag_low, want.lo);
                    if (o_tag_high !== want.hi) report_mismatch("tag_high", o_tag_high, want.hi);
                end
            end
            if (hold_on) begin
                i_stall <= 1'b1;
            end else if (send_gaps) begin
                i_stall <= (gap_len() > 0) || ($urandom_range(0, 3) == 0);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Register write, only while the block is idle.
    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            p1305_pkg::REG_R_LOW:  key_r_lo = val;
            p1305_pkg::REG_R_HIGH: key_r_hi = val;
            p1305_pkg::REG_S_LOW:  key_s_lo = val;
            default:               key_s_hi = val;
        endcase
        i_cfg_valid <= 1'b0;
    endtask

    task automatic load_key(input logic [63:0] rl, rh, sl, sh);
        write_reg(p1305_pkg::REG_R_LOW, rl);
        write_reg(p1305_pkg::REG_R_HIGH, rh);
        write_reg(p1305_pkg::REG_S_LOW, sl);
        write_reg(p1305_pkg::REG_S_HIGH, sh);
    endtask

    // Wait for every tag to arrive, then for the block to go quiet.
    task automatic drain();
        while (pending_blocks.size() > 0 || i_valid || expected_tags.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic queue_message(input int nblk);
        for (int k = 0; k < nblk; k++)
            pending_blocks.push_back(random_block(k == nblk - 1));
    endtask

    // Stimulus.
    initial begin
        t_block_item it;
        err_count = 0;
        hold_req = 1'b0;
        send_gaps = 1'b0;
        acc_h = '0;
        {key_r_lo, key_r_hi, key_s_lo, key_s_hi} = '0;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = p1305_pkg::REG_R_LOW;
        i_cfg_data = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: a fixed key and message, then field extremes.
        load_key(64'h33d6b24b97daed59, 64'h8a6d20b3ad48c69b,
                 64'h1e4f5d0fc2944b58, 64'hc05e434be800ad02);
        pending_blocks.push_back('{64'h6172676f74707972, 64'h6f7220636968706f, 5'd0, 1'b0});
        pending_blocks.push_back('{64'h6f7365507220636d, 64'h6863726165736572, 5'd16, 1'b0});
        pending_blocks.push_back('{64'h7075, 64'h0, 5'd2, 1'b1});
        pending_blocks.push_back('{'1, '1, 5'd0, 1'b1});
        pending_blocks.push_back('{'1, '1, 5'd16, 1'b1});
        pending_blocks.push_back('{'1, '1, 5'd31, 1'b1});
        pending_blocks.push_back('{'1, '1, 5'd8, 1'b1});
        pending_blocks.push_back('{'1, '1, 5'd0, 1'b0});
        pending_blocks.push_back('{'1, '1, 5'd7, 1'b1});
        pending_blocks.push_back('{'1, '1, 5'd9, 1'b1});
        pending_blocks.push_back('{'1, '1, 5'd15, 1'b1});
        pending_blocks.push_back('{'0, '0, 5'd1, 1'b1});
        pending_blocks.push_back('{'0, '0, 5'd0, 1'b1});
        drain();
        load_key('1, '1, '1, '1);
        pending_blocks.push_back('{'1, '1, 5'd31, 1'b0});
        pending_blocks.push_back('{'1, '1, 5'd16, 1'b1});
        pending_blocks.push_back('{'1, '1, 5'd0, 1'b1});
        drain();

        // Random messages under several keys, with idling on both sides.
        send_gaps = 1'b1;
        for (int phase = 0; phase < 6; phase++) begin
            if (phase == 1) load_key('0, '0, '0, '0);
            else load_key({$urandom, $urandom}, {$urandom, $urandom},
                          {$urandom, $urandom}, {$urandom, $urandom});
            while (pending_blocks.size() < 150)
                queue_message($urandom_range(1, 6));
            // A long hold on the result side so that the block backs up.
            if (phase == 2) hold_req = 1'b1;
            drain();
        end

        if (err_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Overall time limit.
    initial begin
        #5ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
